// ===== rtl/core/pfa_pkg.sv =====
package pfa_pkg;

    localparam int PARTS_DEFAULT = 16;
    localparam int SIZE_W        = 20;
    localparam int SLOT_W        = 4;
    localparam int COUNT_W       = 5;
    localparam int MODE_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 5;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTITION_COUNT = 2'd1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_ALLOCATE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [SLOT_W-1:0] slot_index;
        logic [SIZE_W-1:0] amount;
    } t_pfa_in;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] chosen_partition;
        logic [SIZE_W-1:0] free_before;
    } t_pfa_out;

    // Scan token handed from cell to cell; the candidate index travels beside it.
    typedef struct packed {
        logic              live;
        logic              found;
        logic [SIZE_W-1:0] value;
    } t_pfa_tok;

    // Request broadcast shared by all cells during loads, during a scan and at grant time.
    typedef struct packed {
        logic              load_en;
        logic [SLOT_W-1:0] load_slot;
        logic [SIZE_W-1:0] load_value;
        logic              grant_en;
        logic [SIZE_W-1:0] amount;
        logic [MODE_W-1:0] mode;
        logic [COUNT_W-1:0] count;
    } t_pfa_bcast;

endpackage

// ===== rtl/core/pfa_cell.sv =====
module pfa_cell import pfa_pkg::*; #(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_pfa_bcast       i_bcast,
    input  logic [IDX_W-1:0] i_grant_idx,
    input  t_pfa_tok         i_tok,
    input  logic [IDX_W-1:0] i_tok_idx,
    output t_pfa_tok         o_tok,
    output logic [IDX_W-1:0] o_tok_idx
);

    logic [SIZE_W-1:0] r_free;
    logic              r_live;
    logic              r_found;
    logic [SIZE_W-1:0] r_value;
    logic [IDX_W-1:0]  r_idx;

    logic active;
    logic fits;
    logic better;
    logic take;

    assign active = 32'(IDX) < 32'(i_bcast.count);
    assign fits   = i_bcast.amount <= r_free;

    always_comb begin
        case (i_bcast.mode)
            MODE_BEST:  better = r_free < i_tok.value;
            MODE_WORST: better = r_free > i_tok.value;
            default:    better = 1'b0;
        endcase
    end

    // Ties keep the earlier candidate, so the lowest index wins.
    assign take = active && fits && (!i_tok.found || better);

    always_ff @(posedge i_clk) begin
        if (i_bcast.load_en && (32'(i_bcast.load_slot) == IDX)) begin
            r_free <= i_bcast.load_value;
        end else if (i_bcast.grant_en && (32'(i_grant_idx) == IDX)) begin
            r_free <= r_free - i_bcast.amount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= i_tok.live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_found <= 1'b1;
            r_value <= r_free;
            r_idx   <= IDX_W'(IDX);
        end else begin
            r_found <= i_tok.found;
            r_value <= i_tok.value;
            r_idx   <= i_tok_idx;
        end
    end

    assign o_tok.live  = r_live;
    assign o_tok.found = r_found;
    assign o_tok.value = r_value;
    assign o_tok_idx   = r_idx;

endmodule

// ===== rtl/core/partition_fit_allocator.sv =====
// Partition fit allocator. Holds the free size of PARTS partitions, one per cell of a
// chain, and grants allocate requests by first, best or worst fit (ties go to the lowest
// index). A load beat produces no result. An allocate beat launches a token that walks
// the chain one cell per cycle; its result is registered in the output register once
// the token leaves the last cell, and the input stays stalled until then and until the
// output register is free. The granted partition is reduced by the request in the cycle
// the result is registered. Partitions hold no defined size until loaded. Configuration
// writes are always ready.
module partition_fit_allocator import pfa_pkg::*; #(
    parameter int PARTS = PARTS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_pfa_in               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_pfa_out              o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (PARTS > 1) ? $clog2(PARTS) : 1;

    logic [MODE_W-1:0]  r_mode;
    logic [COUNT_W-1:0] r_count;
    logic               r_busy;
    logic [SIZE_W-1:0]  r_amount;
    logic               r_start;
    logic               r_out_valid;
    t_pfa_out           r_out;

    t_pfa_tok           tok     [PARTS+1];
    logic [IDX_W-1:0]   tok_idx [PARTS+1];
    t_pfa_bcast         bcast;

    logic in_accept;
    logic out_free;
    logic is_alloc;
    logic done;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign is_alloc   = i_in_data.req_type == REQ_ALLOCATE;
    assign o_in_stall = r_busy || (is_alloc && !out_free);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign done       = tok[PARTS].live;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_FIRST;
            r_count <= COUNT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FIT_MODE:        r_mode  <= i_cfg_data[MODE_W-1:0];
                REG_PARTITION_COUNT: r_count <= i_cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_start <= in_accept && is_alloc;
            if (in_accept && is_alloc) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && is_alloc) begin
            r_amount <= i_in_data.amount;
        end
    end

    assign tok[0].live  = r_start;
    assign tok[0].found = 1'b0;
    assign tok[0].value = '0;
    assign tok_idx[0]   = '0;

    assign bcast.load_en    = in_accept && !is_alloc;
    assign bcast.load_slot  = i_in_data.slot_index;
    assign bcast.load_value = i_in_data.amount;
    assign bcast.grant_en   = done && tok[PARTS].found;
    assign bcast.amount     = r_amount;
    assign bcast.mode       = r_mode;
    assign bcast.count      = r_count;

    for (genvar g = 0; g < PARTS; g++) begin : g_cell
        pfa_cell #(
            .IDX_W (IDX_W),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_bcast     (bcast),
            .i_grant_idx (tok_idx[PARTS]),
            .i_tok       (tok[g]),
            .i_tok_idx   (tok_idx[g]),
            .o_tok       (tok[g+1]),
            .o_tok_idx   (tok_idx[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            if (tok[PARTS].found) begin
                r_out.granted          <= 1'b1;
                r_out.chosen_partition <= SLOT_W'(32'(tok_idx[PARTS]));
                r_out.free_before      <= tok[PARTS].value;
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A scan result only arrives while a request is outstanding.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> r_busy)
        else $error("scan result without an outstanding request");

    // The output register is empty whenever a result lands in it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> !r_out_valid)
        else $error("result overwrote an untaken beat");

    // No load may hit a partition in the cycle it is being reduced.
    a_no_load_on_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bcast.grant_en |-> !bcast.load_en)
        else $error("load collided with a grant");

    // A refused request reports zeros.
    a_refusal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.granted) |->
            (r_out.chosen_partition == '0 && r_out.free_before == '0))
        else $error("refused request carries nonzero fields");

endmodule

// ===== tb/pfa_grant_checker.sv =====
module pfa_grant_checker import pfa_pkg::*; #(
    parameter int PARTS = PARTS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_pfa_in               i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_pfa_out              i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [SIZE_W-1:0]  free_kb [PARTS];
    logic [MODE_W-1:0]  policy;
    logic [COUNT_W-1:0] parts_cfg;
    t_pfa_out           grant_q [$];
    int                 mismatches = 0;

    assign o_fail_count = mismatches;

    // Scans the partitions in use from index 0 upward. Only a strictly better size
    // replaces the candidate, so a tie keeps the lowest index. First fit and the
    // unused mode keep the first partition that fits.
    function automatic t_pfa_out choose_partition(input logic [SIZE_W-1:0] request);
        t_pfa_out pick;
        int       limit;
        int       best;
        bit       found;
        limit = (parts_cfg > PARTS) ? PARTS : int'(parts_cfg);
        found = 1'b0;
        best  = 0;
        for (int i = 0; i < limit; i++) begin
            if (request <= free_kb[i]) begin
                if (!found) begin
                    found = 1'b1;
                    best  = i;
                end else if (policy == MODE_BEST && free_kb[i] < free_kb[best]) begin
                    best = i;
                end else if (policy == MODE_WORST && free_kb[i] > free_kb[best]) begin
                    best = i;
                end
            end
        end
        pick.granted          = found;
        pick.chosen_partition = found ? SLOT_W'(best) : '0;
        pick.free_before      = found ? free_kb[best] : '0;
        return pick;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pfa_out want;
        if (!i_rst_n) begin
            policy    = MODE_FIRST;
            parts_cfg = COUNT_RESET;
            grant_q.delete();
            foreach (free_kb[i]) free_kb[i] = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_FIT_MODE) begin
                    policy = i_cfg_data[MODE_W-1:0];
                end else if (i_cfg_index == REG_PARTITION_COUNT) begin
                    parts_cfg = i_cfg_data[COUNT_W-1:0];
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (grant_q.size() == 0) begin
                    $error("result beat with no allocate waiting: %p", i_out_data);
                    mismatches++;
                end else begin
                    want = grant_q.pop_front();
                    if (i_out_data.granted !== want.granted) begin
                        $error("granted: expected %0d, got %0d",
                               want.granted, i_out_data.granted);
                        mismatches++;
                    end
                    if (i_out_data.chosen_partition !== want.chosen_partition) begin
                        $error("chosen_partition: expected %0d, got %0d",
                               want.chosen_partition, i_out_data.chosen_partition);
                        mismatches++;
                    end
                    if (i_out_data.free_before !== want.free_before) begin
                        $error("free_before: expected %0d, got %0d",
                               want.free_before, i_out_data.free_before);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.req_type == REQ_LOAD) begin
                    if (i_in_data.slot_index < PARTS) begin
                        free_kb[i_in_data.slot_index] = i_in_data.amount;
                    end
                end else begin
                    want = choose_partition(i_in_data.amount);
                    if (want.granted) begin
                        free_kb[want.chosen_partition] = want.free_before - i_in_data.amount;
                    end
                    grant_q = {grant_q, want};
                end
            end
        end
        o_pending <= grant_q.size();
    end

endmodule

// ===== tb/tb_partition_fit_allocator.sv =====
module tb_partition_fit_allocator;
    import pfa_pkg::*;

    localparam int PARTS         = PARTS_DEFAULT;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 2 * PARTS + 8;
    localparam int HOLD_LEN      = 300;
    localparam int N_PHASES      = 20;
    localparam int PHASE_ITEMS   = 50;

    // Codes the block has no use for; writing them must change nothing.
    localparam logic [MODE_W-1:0]    FIT_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_pfa_in               in_data   = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_pfa_out              out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_go        = 1'b0;
    int cycles         = 0;

    logic [SIZE_W-1:0] seed_kb [16] = '{
        20'hFFFFF, 20'd0, 20'd500, 20'd300, 20'd500, 20'd300, 20'd1000, 20'd1000,
        20'h80000, 20'h7FFFF, 20'd16, 20'd16, 20'd2048, 20'd300, 20'd500, 20'hFFFFF
    };

    partition_fit_allocator #(.PARTS(PARTS)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pfa_grant_checker #(.PARTS(PARTS)) u_grant_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= LIMIT_CYCLES) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result side. A long hold-off is counted here while the sender keeps offering.
    initial begin : receiver
        int k;
        forever begin
            @(posedge clk);
            if (hold_go) begin
                hold_go = 1'b0;
                for (k = 0; k < HOLD_LEN; k++) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Valid is left high after a beat goes through; it drops only for an idle cycle
    // or when the stimulus stops.
    task automatic send_beat(input t_pfa_in beat);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        // No load beat is left in flight here: a load is written when it is accepted.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_policy(input logic [MODE_W-1:0] mode,
                              input logic [COUNT_W-1:0] count);
        settle();
        write_reg(REG_FIT_MODE, CFG_DATA_W'(mode));
        write_reg(REG_PARTITION_COUNT, CFG_DATA_W'(count));
        cfg_valid <= 1'b0;
    endtask

    function automatic t_pfa_in alloc_beat(input logic [SIZE_W-1:0] request);
        return t_pfa_in'{req_type: REQ_ALLOCATE, slot_index: '0, amount: request};
    endfunction

    initial begin : stimulus
        t_pfa_in           beat;
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] count;
        int                 ph;
        int                 n;

        send_idle_pct  = 15;
        recv_stall_pct = 62;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_SPARE_A, 5'h1F);
        write_reg(REG_SPARE_B, 5'h15);
        write_reg(REG_FIT_MODE, CFG_DATA_W'(MODE_FIRST));
        write_reg(REG_PARTITION_COUNT, CFG_DATA_W'(COUNT_RESET));
        cfg_valid <= 1'b0;

        // Every partition is loaded before any allocate can scan it.
        for (n = 0; n < 16; n++) begin
            send_beat(t_pfa_in'{req_type: REQ_LOAD, slot_index: SLOT_W'(n),
                                amount: seed_kb[n]});
        end
        // Zero request fits anything; full-size requests exhaust partition 0, then partition 15.
        send_beat(alloc_beat('0));
        send_beat(alloc_beat('1));
        send_beat(alloc_beat('1));
        set_policy(MODE_BEST, COUNT_RESET);
        send_beat(alloc_beat(20'd300));
        send_beat(alloc_beat(20'd301));
        set_policy(MODE_WORST, COUNT_RESET);
        send_beat(alloc_beat(20'd1));
        send_beat(alloc_beat(20'd1));
        set_policy(FIT_SPARE, COUNT_RESET);
        send_beat(alloc_beat(20'd400));
        set_policy(MODE_FIRST, 5'd0);
        send_beat(alloc_beat('0));
        set_policy(MODE_BEST, 5'd31);
        send_beat(alloc_beat('0));

        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph < N_PHASES / 3) begin
                send_idle_pct  = 15;
                recv_stall_pct = 62;
            end else if (ph < 2 * N_PHASES / 3) begin
                send_idle_pct  = 62;
                recv_stall_pct = 15;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            mode = (ph < 8) ? MODE_W'(ph % 4) : MODE_W'($urandom_range(0, 3));
            case (ph)
                0:       count = 5'd1;
                1:       count = 5'd0;
                2:       count = 5'd31;
                3:       count = COUNT_RESET;
                default: count = ($urandom_range(0, 2) == 0) ?
                                 COUNT_W'($urandom_range(0, 31)) : COUNT_RESET;
            endcase
            set_policy(mode, count);
            if (ph == 2) hold_go = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                beat.req_type   = ($urandom_range(0, 99) < 40) ? REQ_LOAD : REQ_ALLOCATE;
                beat.slot_index = SLOT_W'($urandom_range(0, 15));
                // Sizes from a coarse grid make ties and exact fits common.
                case ($urandom_range(0, 9))
                    0:       beat.amount = '0;
                    1:       beat.amount = '1;
                    2, 3, 4: beat.amount = SIZE_W'($urandom_range(0, 7) * 128);
                    5, 6:    beat.amount = SIZE_W'($urandom_range(0, 4095));
                    default: beat.amount = SIZE_W'($urandom());
                endcase
                send_beat(beat);
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pfa_pkg.sv
rtl/core/pfa_cell.sv
rtl/core/partition_fit_allocator.sv
tb/pfa_grant_checker.sv
tb/tb_partition_fit_allocator.sv
